// ----- hw/rtl/hsvrgb_pkg.sv -----
// Shared constants, stage-enable types and curve table functions for the HSL/HSV to RGB converter.
package hsvrgb_pkg;

  // Width of every data field on the request channels, apart from the mode bit.
  localparam int FIELD_W = 16;

  // Pipeline split: color mixing stages, then sRGB decoding stages.
  localparam int COLOR_STAGES  = 4;
  localparam int DECODE_STAGES = 4;
  localparam int NUM_STAGES    = COLOR_STAGES + DECODE_STAGES;

  typedef logic [COLOR_STAGES-1:0]  color_en_t;
  typedef logic [DECODE_STAGES-1:0] decode_en_t;

  // Knee of the sRGB decoding curve, 0.04045, as a ratio.
  localparam longint unsigned KNEE_NUM = 64'd4045;
  localparam longint unsigned KNEE_DEN = 64'd100000;

  // Linear segment below the knee: x / 12.92 = (50x + 323) / 646, rounded.
  localparam int LOW_NUM  = 50;
  localparam int LOW_BIAS = 323;
  localparam int LOW_DEN  = 646;

  // Working precision used while building the curve table.
  localparam int CURVE_WP = 30;

  // Restoring division on 64-bit values, used only while the table is built.
  function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      r = (r << 1) | ((num >> b) & 64'd1);
      if (r >= den) begin
        r = r - den;
        q = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  // Fixed-point product at CURVE_WP fraction bits.
  function automatic longint unsigned mulw(longint unsigned a, longint unsigned b);
    return (a * b) >> CURVE_WP;
  endfunction

  function automatic longint unsigned pow5w(longint unsigned r);
    longint unsigned r2;
    longint unsigned r4;
    r2 = mulw(r, r);
    r4 = mulw(r2, r2);
    return mulw(r4, r);
  endfunction

  // Largest r with r^5 <= w, found by bisection.
  function automatic longint unsigned root5w(longint unsigned w);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 64'd0;
    hi = 64'd1 << CURVE_WP;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      if (pow5w(mid) <= w) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    return lo;
  endfunction

  // One point of ((x + 0.055) / 1.055)^2.4 at x = i / (n - 1), with f fraction bits.
  // The power 2.4 is u^2 times the fifth root of u^2.
  function automatic longint unsigned curve_entry(longint unsigned i, longint unsigned n,
                                                  int f);
    longint unsigned n1;
    longint unsigned den;
    longint unsigned num;
    longint unsigned u;
    longint unsigned w;
    longint unsigned r;
    longint unsigned v;
    longint unsigned q;
    n1  = n - 64'd1;
    den = 64'd1055 * n1;
    num = (64'd1000 * i + 64'd55 * n1) << CURVE_WP;
    u   = udiv(num + (den >> 1), den);
    w   = (u * u + (64'd1 << (CURVE_WP - 1))) >> CURVE_WP;
    r   = root5w(w);
    v   = (w * r + (64'd1 << (CURVE_WP - 1))) >> CURVE_WP;
    q   = (v + (64'd1 << (CURVE_WP - f - 1))) >> (CURVE_WP - f);
    if (q > (64'd1 << f)) begin
      q = 64'd1 << f;
    end
    return q;
  endfunction

endpackage

// ----- hw/rtl/hsvrgb_if.sv -----
// Valid/ready channel interfaces for color requests and RGB results.
interface hsvrgb_in_if;
  import hsvrgb_pkg::*;

  logic               valid;
  logic               ready;
  logic               mode;
  logic [FIELD_W-1:0] hue;
  logic [FIELD_W-1:0] saturation;
  logic [FIELD_W-1:0] level;

  modport source (output valid, mode, hue, saturation, level, input ready);
  modport sink (input valid, mode, hue, saturation, level, output ready);
endinterface

interface hsvrgb_out_if;
  import hsvrgb_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] red;
  logic [FIELD_W-1:0] green;
  logic [FIELD_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

// ----- hw/rtl/hsl_hsv_to_rgb_converter_top.sv -----
// Top level of the HSL/HSV to RGB converter: request channels, valid chain and config register.
// The converter takes one color request per clock while the output side is not stalled and
// returns its red, green and blue in order: four stages mix the hue ramps
// with chroma and level, four more decode sRGB to linear light when output_linear is set
// (through a curve table of CURVE_TABLE_ENTRIES points, read at two neighboring addresses
// per channel and interpolated). Every stage has its own valid bit and holds its item
// while the stage after it is full, so empty stages fill up during an output stall; the
// input ready follows the output ready combinationally through that valid chain. The
// curve table is computed at elaboration and needs no loading. Write output_linear only
// while no request is in flight.
module hsl_hsv_to_rgb_converter_top #(
  parameter int FRAC_BITS           = 16,
  parameter int CURVE_TABLE_ENTRIES = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  hsvrgb_in_if.sink    in_req_i,
  hsvrgb_out_if.source out_req_o
);
  import hsvrgb_pkg::*;

  // Configuration register.
  logic linear_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      linear_q <= 1'b0;
    end else if (cfg_we_i) begin
      linear_q <= cfg_wdata_i;
    end
  end

  // Valid chain: a stage loads when it is empty or its content moves on.
  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES:0]   adv;

  always_comb begin
    adv[NUM_STAGES] = out_req_o.ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_req_i.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_req_i.ready  = adv[0];
  assign out_req_o.valid = v_q[NUM_STAGES-1];

  // Color mixing stages.
  logic [2:0][FRAC_BITS-1:0] mixed;
  logic [2:0][FRAC_BITS-1:0] decoded;

  hsvrgb_color #(
    .FRAC_BITS (FRAC_BITS)
  ) u_color (
    .clk_i   (clk_i),
    .en_i    (adv[COLOR_STAGES-1:0]),
    .mode_i  (in_req_i.mode),
    .hue_i   (FRAC_BITS'(in_req_i.hue)),
    .sat_i   (FRAC_BITS'(in_req_i.saturation)),
    .level_i (FRAC_BITS'(in_req_i.level)),
    .chan_o  (mixed)
  );

  // Per-channel sRGB decoding stages.
  for (genvar g = 0; g < 3; g++) begin : g_dec
    hsvrgb_decode #(
      .FRAC_BITS (FRAC_BITS),
      .ENTRIES   (CURVE_TABLE_ENTRIES)
    ) u_decode (
      .clk_i    (clk_i),
      .en_i     (adv[NUM_STAGES-1:COLOR_STAGES]),
      .linear_i (linear_q),
      .chan_i   (mixed[g]),
      .chan_o   (decoded[g])
    );
  end

  assign out_req_o.red   = FIELD_W'(decoded[0]);
  assign out_req_o.green = FIELD_W'(decoded[1]);
  assign out_req_o.blue  = FIELD_W'(decoded[2]);

  logic in_acc;
  logic out_acc;
  assign in_acc  = in_req_i.valid && in_req_i.ready;
  assign out_acc = out_req_o.valid && out_req_o.ready;

  // A full pipeline with a stalled output must refuse new requests.
  a_full_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
      ((&v_q) && !out_req_o.ready) |-> !in_req_i.ready)
    else $error("request accepted into a full, stalled pipeline");

  // The number of requests in flight changes only by accepted requests.
  a_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
      1'b1 |=> ($countones(v_q) == $past($countones(v_q)) + int'($past(in_acc))
                                   - int'($past(out_acc))))
    else $error("request lost or duplicated inside the pipeline");

  // A stage whose successor is blocked keeps its request.
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
      1'b1 |=> (($past(v_q & ~adv[NUM_STAGES:1]) & ~v_q) == '0))
    else $error("stalled stage dropped its request");

endmodule

// ----- hw/rtl/hsvrgb_color.sv -----
// Four-stage color mixer: hue ramps, chroma, channel products and final clamp.
module hsvrgb_color #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  hsvrgb_pkg::color_en_t           en_i,
  input  logic                            mode_i,
  input  logic [FRAC_BITS-1:0]            hue_i,
  input  logic [FRAC_BITS-1:0]            sat_i,
  input  logic [FRAC_BITS-1:0]            level_i,
  output logic [2:0][FRAC_BITS-1:0]       chan_o
);
  import hsvrgb_pkg::*;

  localparam int SW = FRAC_BITS + 4;        // signed width for hue and lightness terms
  localparam int CW = 2 * FRAC_BITS;        // chroma product width
  localparam int PW = 2 * FRAC_BITS + 3;    // signed channel product width

  localparam logic signed [SW-1:0] ONE_S   = SW'(64'd1 << FRAC_BITS);
  localparam logic signed [SW-1:0] TWO_S   = SW'(64'd2 << FRAC_BITS);
  localparam logic signed [SW-1:0] THREE_S = SW'(64'd3 << FRAC_BITS);
  localparam logic signed [SW-1:0] FOUR_S  = SW'(64'd4 << FRAC_BITS);
  localparam logic [CW-1:0]        HALF_C  = CW'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [PW-1:0] HALF_P  = PW'(64'd1 << (FRAC_BITS - 1));
  localparam logic [FRAC_BITS+2:0] MAX_Y   = (FRAC_BITS+3)'((64'd1 << FRAC_BITS) - 64'd1);

  function automatic logic signed [SW-1:0] abs_s(logic signed [SW-1:0] a);
    return (a < 0) ? -a : a;
  endfunction

  // Clamp to the closed range zero through one.
  function automatic logic [FRAC_BITS:0] sat01(logic signed [SW-1:0] a);
    logic [FRAC_BITS:0] res;
    if (a < 0) begin
      res = '0;
    end else if (a > ONE_S) begin
      res = ONE_S[FRAC_BITS:0];
    end else begin
      res = a[FRAC_BITS:0];
    end
    return res;
  endfunction

  // Stage 1 registers.
  logic                      mode1_q;
  logic [FRAC_BITS-1:0]      lvl1_q;
  logic [FRAC_BITS-1:0]      sat1_q;
  logic [FRAC_BITS:0]        mul1_q;
  logic [2:0][FRAC_BITS:0]   ramp1_q;
  // Stage 2 registers.
  logic                      mode2_q;
  logic [FRAC_BITS-1:0]      lvl2_q;
  logic [FRAC_BITS-1:0]      chroma2_q;
  logic [2:0][FRAC_BITS:0]   ramp2_q;
  // Stage 3 registers.
  logic [FRAC_BITS-1:0]      lvl3_q;
  logic signed [PW-1:0]      prod3_q [3];
  // Stage 4 registers.
  logic [2:0][FRAC_BITS-1:0] chan4_q;

  // Stage 1: piecewise-linear hue ramps and the chroma multiplicand.
  logic signed [SW-1:0]    h6;
  logic signed [SW-1:0]    tw;
  logic signed [SW-1:0]    kk;
  logic [FRAC_BITS:0]      mul1_d;
  logic [2:0][FRAC_BITS:0] ramp1_d;

  always_comb begin
    h6 = SW'({hue_i, 2'b00}) + SW'({hue_i, 1'b0});
    ramp1_d[0] = sat01(abs_s(h6 - THREE_S) - ONE_S);
    ramp1_d[1] = sat01(TWO_S - abs_s(h6 - TWO_S));
    ramp1_d[2] = sat01(TWO_S - abs_s(h6 - FOUR_S));
    tw = SW'({level_i, 1'b0}) - ONE_S;
    kk = ONE_S - abs_s(tw);
    mul1_d = mode_i ? {1'b0, level_i} : kk[FRAC_BITS:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mode1_q <= mode_i;
      lvl1_q  <= level_i;
      sat1_q  <= sat_i;
      mul1_q  <= mul1_d;
      ramp1_q <= ramp1_d;
    end
  end

  // Stage 2: chroma, rounded to nearest.
  logic [CW-1:0] cprod;

  always_comb begin
    cprod = {{(FRAC_BITS-1){1'b0}}, mul1_q} * {{FRAC_BITS{1'b0}}, sat1_q} + HALF_C;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      mode2_q   <= mode1_q;
      lvl2_q    <= lvl1_q;
      chroma2_q <= cprod[CW-1:FRAC_BITS];
      ramp2_q   <= ramp1_q;
    end
  end

  // Stage 3: offset ramp times chroma per channel.
  logic signed [FRAC_BITS+1:0] base;
  logic signed [FRAC_BITS+1:0] dlt [3];
  logic signed [FRAC_BITS:0]   chroma_s;
  logic signed [PW-1:0]        prod3_d [3];

  always_comb begin
    base     = mode2_q ? (FRAC_BITS+2)'(64'd1 << FRAC_BITS)
                       : (FRAC_BITS+2)'(64'd1 << (FRAC_BITS - 1));
    chroma_s = $signed({1'b0, chroma2_q});
    for (int k = 0; k < 3; k++) begin
      dlt[k]     = $signed({1'b0, ramp2_q[k]}) - base;
      prod3_d[k] = PW'(dlt[k]) * PW'(chroma_s);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      lvl3_q <= lvl2_q;
      for (int k = 0; k < 3; k++) begin
        prod3_q[k] <= prod3_d[k];
      end
    end
  end

  // Stage 4: add the level, round half up and clamp to the format.
  logic signed [PW-1:0]      total [3];
  logic signed [PW-1:0]      shifted [3];
  logic [2:0][FRAC_BITS-1:0] chan4_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      total[k]   = $signed({3'b000, lvl3_q, {FRAC_BITS{1'b0}}}) + prod3_q[k] + HALF_P;
      shifted[k] = total[k] >>> FRAC_BITS;
      if (total[k] < 0) begin
        chan4_d[k] = '0;
      end else if (shifted[k][FRAC_BITS+2:0] > MAX_Y) begin
        chan4_d[k] = MAX_Y[FRAC_BITS-1:0];
      end else begin
        chan4_d[k] = shifted[k][FRAC_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      chan4_q <= chan4_d;
    end
  end

  assign chan_o = chan4_q;

endmodule

// ----- hw/rtl/hsvrgb_curve_rom.sv -----
// Dual-read ROM holding the sRGB decoding curve, filled at elaboration.
module hsvrgb_curve_rom #(
  parameter int FRAC_BITS = 16,
  parameter int ENTRIES   = 1024
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [$clog2(ENTRIES)-1:0] addr_i,
  output logic [FRAC_BITS:0]         lo_o,
  output logic [FRAC_BITS:0]         hi_o
);
  import hsvrgb_pkg::*;

  localparam int IB = $clog2(ENTRIES);

  typedef logic [FRAC_BITS:0] curve_t [ENTRIES];

  function automatic curve_t build_curve();
    curve_t tbl;
    for (int i = 0; i < ENTRIES; i++) begin
      tbl[i] = (FRAC_BITS+1)'(curve_entry(longint'(i), longint'(ENTRIES), FRAC_BITS));
    end
    return tbl;
  endfunction

  localparam curve_t CURVE = build_curve();

  // The upper address never passes the last entry since the lower one stops one short.
  logic [IB-1:0] addr_hi;
  assign addr_hi = addr_i + IB'(1);

  // Registered reads of neighboring points.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_o <= CURVE[addr_i];
      hi_o <= CURVE[addr_hi];
    end
  end

endmodule

// ----- hw/rtl/hsvrgb_decode.sv -----
// Four-stage sRGB-to-linear decoder for one channel, with pass-through when disabled.
module hsvrgb_decode #(
  parameter int FRAC_BITS = 16,
  parameter int ENTRIES   = 1024
) (
  input  logic                   clk_i,
  input  hsvrgb_pkg::decode_en_t en_i,
  input  logic                   linear_i,
  input  logic [FRAC_BITS-1:0]   chan_i,
  output logic [FRAC_BITS-1:0]   chan_o
);
  import hsvrgb_pkg::*;

  localparam int IB = $clog2(ENTRIES);
  localparam longint unsigned KNEE =
      (KNEE_NUM * (64'd1 << FRAC_BITS) + KNEE_DEN / 2) / KNEE_DEN;
  // Width of the numerator 50x + 323 below the knee.
  localparam int DW  = $clog2(LOW_NUM * KNEE + LOW_BIAS + 1);
  // Reciprocal of 646 exact for every numerator of DW bits.
  localparam int SH  = DW + $clog2(LOW_DEN);
  localparam int MW  = SH - 8;
  localparam longint unsigned MULT_L = ((64'd1 << SH) + LOW_DEN - 1) / LOW_DEN;
  localparam logic [MW-1:0] MULT = MW'(MULT_L);
  localparam int LW  = DW + MW;
  localparam int IW  = 2 * FRAC_BITS + 2;
  localparam logic [IW-1:0]        HALF_I = IW'(64'd1 << (FRAC_BITS - 1));
  localparam logic [FRAC_BITS+1:0] MAX_Y  = (FRAC_BITS+2)'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic [FRAC_BITS-1:0] KNEE_V = FRAC_BITS'(KNEE);

  // Stage 5: table position, knee test and linear-segment numerator.
  logic [FRAC_BITS+IB-1:0] pos;
  logic [FRAC_BITS+6:0]    nfull;
  logic [FRAC_BITS-1:0]    ch5_q;
  logic [IB-1:0]           idx5_q;
  logic [FRAC_BITS-1:0]    fr5_q;
  logic                    below5_q;
  logic [DW-1:0]           num5_q;

  always_comb begin
    pos   = {{IB{1'b0}}, chan_i} * (FRAC_BITS+IB)'(ENTRIES - 1);
    nfull = {7'b0, chan_i} * (FRAC_BITS+7)'(LOW_NUM) + (FRAC_BITS+7)'(LOW_BIAS);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ch5_q    <= chan_i;
      idx5_q   <= pos[FRAC_BITS +: IB];
      fr5_q    <= pos[FRAC_BITS-1:0];
      below5_q <= (chan_i < KNEE_V);
      num5_q   <= nfull[DW-1:0];
    end
  end

  // Stage 6: table read and reciprocal product for the linear segment.
  logic [FRAC_BITS:0]   t0_6;
  logic [FRAC_BITS:0]   t1_6;
  logic [FRAC_BITS-1:0] ch6_q;
  logic [FRAC_BITS-1:0] fr6_q;
  logic                 below6_q;
  logic [LW-1:0]        low6_q;

  hsvrgb_curve_rom #(
    .FRAC_BITS (FRAC_BITS),
    .ENTRIES   (ENTRIES)
  ) u_rom (
    .clk_i  (clk_i),
    .en_i   (en_i[1]),
    .addr_i (idx5_q),
    .lo_o   (t0_6),
    .hi_o   (t1_6)
  );

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      ch6_q    <= ch5_q;
      fr6_q    <= fr5_q;
      below6_q <= below5_q;
      low6_q   <= {{MW{1'b0}}, num5_q} * {{DW{1'b0}}, MULT};
    end
  end

  // Stage 7: interpolation product between neighboring points.
  logic [FRAC_BITS:0]   dt;
  logic [IW-1:0]        iprod7_q;
  logic [FRAC_BITS:0]   t0_7_q;
  logic [FRAC_BITS-1:0] ch7_q;
  logic                 below7_q;
  logic [FRAC_BITS-1:0] lowq7_q;

  assign dt = (t1_6 >= t0_6) ? (t1_6 - t0_6) : '0;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      iprod7_q <= {{(FRAC_BITS+1){1'b0}}, dt} * {{(FRAC_BITS+2){1'b0}}, fr6_q};
      t0_7_q   <= t0_6;
      ch7_q    <= ch6_q;
      below7_q <= below6_q;
      lowq7_q  <= FRAC_BITS'(low6_q[LW-1:SH]);
    end
  end

  // Stage 8: round the interpolation, clamp, and pick the decoded or plain value.
  logic [IW-1:0]        iround;
  logic [FRAC_BITS+1:0] yint;
  logic [FRAC_BITS-1:0] curve_y;
  logic [FRAC_BITS-1:0] out8_d;
  logic [FRAC_BITS-1:0] out8_q;

  always_comb begin
    iround  = iprod7_q + HALF_I;
    yint    = (FRAC_BITS+2)'(t0_7_q) + iround[FRAC_BITS +: FRAC_BITS+2];
    curve_y = (yint > MAX_Y) ? MAX_Y[FRAC_BITS-1:0] : yint[FRAC_BITS-1:0];
    if (!linear_i) begin
      out8_d = ch7_q;
    end else if (below7_q) begin
      out8_d = lowq7_q;
    end else begin
      out8_d = curve_y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      out8_q <= out8_d;
    end
  end

  assign chan_o = out8_q;

endmodule

// ----- verif/hsl_hsv_to_rgb_converter_top_tb.sv -----
// Self-checking testbench for the HSL/HSV to RGB converter with optional sRGB decoding.
`timescale 1ns / 100ps

module hsl_hsv_to_rgb_converter_top_tb;
  import hsvrgb_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam int GAMMA_PTS = 1024;

  // Fixed-point helpers at FRAC_BITS fraction bits.
  localparam longint FX_ONE  = 64'sd1 << FRAC_BITS;
  localparam longint FX_MAX  = FX_ONE - 1;
  localparam longint FX_HALF = FX_ONE / 2;
  // Knee of the decoding curve, 0.04045, rounded to the format.
  localparam longint KNEE    = (4045 * FX_ONE + 50000) / 100000;
  // Working precision for building the gamma table.
  localparam int     WP      = 30;

  localparam bit OUT_SRGB   = 1'b0;
  localparam bit OUT_LINEAR = 1'b1;

  typedef enum logic {
    MODE_HSL = 1'b0,
    MODE_HSV = 1'b1
  } color_mode_e;

  typedef struct {
    color_mode_e        mode;
    logic [FIELD_W-1:0] hue;
    logic [FIELD_W-1:0] sat;
    logic [FIELD_W-1:0] level;
  } color_req_t;

  typedef struct {
    logic [FIELD_W-1:0] red;
    logic [FIELD_W-1:0] green;
    logic [FIELD_W-1:0] blue;
  } rgb_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  hsvrgb_in_if  color_if ();
  hsvrgb_out_if rgb_if ();

  hsl_hsv_to_rgb_converter_top #(
    .FRAC_BITS          (FRAC_BITS),
    .CURVE_TABLE_ENTRIES(GAMMA_PTS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_req_i   (color_if),
    .out_req_o  (rgb_if)
  );

  // Colors waiting to be sent, and RGB results predicted for accepted requests.
  color_req_t pending_colors [$];
  rgb_t       expected_rgb [$];
  color_req_t on_bus;
  longint unsigned gamma_rom [GAMMA_PTS];

  bit linear_cfg;
  bit send_burst;
  bit take_burst;
  int send_wait;
  int take_wait;
  int n_sent;
  int n_hsv;
  int n_linear;
  int n_checked;
  int n_mismatch;
  int n_settings;

  // Corners of the color space, sector boundaries and greys around the knee.
  color_req_t directed_colors [13] = '{
    '{MODE_HSL, 16'h0000, 16'h0000, 16'h0000},
    '{MODE_HSV, 16'hFFFF, 16'hFFFF, 16'hFFFF},
    '{MODE_HSL, 16'hFFFF, 16'hFFFF, 16'hFFFF},
    '{MODE_HSL, 16'h8000, 16'hFFFF, 16'h8000},
    '{MODE_HSL, 16'h7FFF, 16'hFFFF, 16'h7FFF},
    '{MODE_HSV, 16'd10923, 16'hFFFF, 16'hFFFF},
    '{MODE_HSV, 16'd21845, 16'h8000, 16'hC000},
    '{MODE_HSL, 16'd43691, 16'hFFFF, 16'h4000},
    '{MODE_HSL, 16'd54613, 16'h1234, 16'hA5A5},
    '{MODE_HSV, 16'h0000, 16'h0000, 16'd2650},
    '{MODE_HSV, 16'h0000, 16'h0000, 16'd2651},
    '{MODE_HSL, 16'h0000, 16'h0000, 16'd2652},
    '{MODE_HSV, 16'h5555, 16'hAAAA, 16'h5555}
  };

  function automatic longint abs_fx(longint a);
    return (a < 0) ? -a : a;
  endfunction

  function automatic longint clip_unit(longint a);
    return (a < 0) ? 64'sd0 : ((a > FX_ONE) ? FX_ONE : a);
  endfunction

  // Expected RGB for one color request under the given output setting.
  function automatic rgb_t predict_rgb(color_req_t req, bit linear);
    longint h6;
    longint lvl;
    longint sat;
    longint chroma;
    longint base;
    longint total;
    longint clipped;
    longint ramp [3];
    longint unsigned x;
    longint unsigned y;
    longint unsigned pos;
    longint unsigned idx;
    longint unsigned fr;
    longint unsigned t0;
    longint unsigned t1;
    logic [FIELD_W-1:0] chan [3];
    rgb_t res;
    lvl = longint'(req.level) & FX_MAX;
    sat = longint'(req.sat) & FX_MAX;
    h6  = 6 * (longint'(req.hue) & FX_MAX);

    // Piecewise-linear hue ramps for red, green and blue.
    ramp[0] = clip_unit(abs_fx(h6 - 3 * FX_ONE) - FX_ONE);
    ramp[1] = clip_unit(2 * FX_ONE - abs_fx(h6 - 2 * FX_ONE));
    ramp[2] = clip_unit(2 * FX_ONE - abs_fx(h6 - 4 * FX_ONE));

    if (req.mode == MODE_HSL) begin
      chroma = ((FX_ONE - abs_fx(2 * lvl - FX_ONE)) * sat + FX_HALF) >>> FRAC_BITS;
      base   = FX_HALF;
    end else begin
      chroma = (lvl * sat + FX_HALF) >>> FRAC_BITS;
      base   = FX_ONE;
    end

    for (int k = 0; k < 3; k++) begin
      // Scale, offset and saturate to the largest representable fraction.
      total = lvl * FX_ONE + (ramp[k] - base) * chroma + FX_HALF;
      if (total < 0) begin
        x = 0;
      end else begin
        clipped = total >>> FRAC_BITS;
        x = (clipped > FX_MAX) ? FX_MAX : clipped;
      end

      // Optional sRGB decoding: linear segment below the knee, table above it.
      if (linear) begin
        if (x < KNEE) begin
          y = (x * 50 + 323) / 646;
        end else begin
          pos = x * (GAMMA_PTS - 1);
          idx = pos >> FRAC_BITS;
          fr  = pos & FX_MAX;
          if (idx > GAMMA_PTS - 2) begin
            idx = GAMMA_PTS - 2;
            fr  = FX_ONE;
          end
          t0 = gamma_rom[idx];
          t1 = gamma_rom[idx + 1];
          y  = (t1 >= t0) ? t0 + (((t1 - t0) * fr + FX_HALF) >> FRAC_BITS) : t0;
        end
        x = (y > FX_MAX) ? FX_MAX : y;
      end
      chan[k] = x[FIELD_W-1:0];
    end
    res.red   = chan[0];
    res.green = chan[1];
    res.blue  = chan[2];
    return res;
  endfunction

  // Gamma table: ((x + 0.055) / 1.055)^2.4 computed as u^2 times the fifth root of u^2.
  initial begin : fill_gamma_rom
    longint unsigned n1;
    longint unsigned den;
    longint unsigned u;
    longint unsigned w;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned r2;
    longint unsigned r4;
    longint unsigned v;
    longint unsigned q;
    n1  = GAMMA_PTS - 1;
    den = 1055 * n1;
    for (longint unsigned i = 0; i < GAMMA_PTS; i++) begin
      u  = (((1000 * i + 55 * n1) << WP) + den / 2) / den;
      w  = (u * u + (64'd1 << (WP - 1))) >> WP;
      lo = 0;
      hi = 64'd1 << WP;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        r2  = (mid * mid) >> WP;
        r4  = (r2 * r2) >> WP;
        if (((r4 * mid) >> WP) <= w) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
      v = (w * lo + (64'd1 << (WP - 1))) >> WP;
      q = (v + (64'd1 << (WP - FRAC_BITS - 1))) >> (WP - FRAC_BITS);
      gamma_rom[i] = (q > FX_ONE) ? FX_ONE : q;
    end
  end

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Request driver: presents pending colors, predicting each one as it is accepted.
  always @(posedge clk_i) begin : color_driver
    logic next_valid;
    if (!rst_ni) begin
      color_if.valid      <= 1'b0;
      color_if.mode       <= MODE_HSL;
      color_if.hue        <= '0;
      color_if.saturation <= '0;
      color_if.level      <= '0;
      send_wait = 0;
    end else begin
      next_valid = color_if.valid;
      if (color_if.valid && color_if.ready) begin
        expected_rgb.push_back(predict_rgb(on_bus, linear_cfg));
        n_sent++;
        if (on_bus.mode == MODE_HSV) n_hsv++;
        if (linear_cfg) n_linear++;
        next_valid = 1'b0;
        if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
        send_wait = send_burst ? 0 : $urandom_range(0, 19);
      end
      if (!next_valid) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (pending_colors.size() != 0) begin
          on_bus = pending_colors.pop_front();
          color_if.mode       <= on_bus.mode;
          color_if.hue        <= on_bus.hue;
          color_if.saturation <= on_bus.sat;
          color_if.level      <= on_bus.level;
          next_valid = 1'b1;
        end
      end
      color_if.valid <= next_valid;
    end
  end

  // Result monitor: stalls at random and checks each result against the oldest prediction.
  always @(posedge clk_i) begin : rgb_monitor
    rgb_t want;
    logic next_ready;
    if (!rst_ni) begin
      rgb_if.ready <= 1'b0;
      take_wait = 0;
    end else begin
      next_ready = rgb_if.ready;
      if (rgb_if.valid && rgb_if.ready) begin
        if (expected_rgb.size() == 0) begin
          $display("%0t: unexpected result red=%h green=%h blue=%h", $time,
                   rgb_if.red, rgb_if.green, rgb_if.blue);
          n_mismatch++;
        end else begin
          want = expected_rgb.pop_front();
          n_checked++;
          if (rgb_if.red !== want.red) begin
            $display("%0t: red expected %h, got %h", $time, want.red, rgb_if.red);
            n_mismatch++;
          end
          if (rgb_if.green !== want.green) begin
            $display("%0t: green expected %h, got %h", $time, want.green, rgb_if.green);
            n_mismatch++;
          end
          if (rgb_if.blue !== want.blue) begin
            $display("%0t: blue expected %h, got %h", $time, want.blue, rgb_if.blue);
            n_mismatch++;
          end
        end
        if ($urandom_range(0, 49) == 0) take_burst = !take_burst;
        take_wait = take_burst ? 0 : $urandom_range(0, 19);
        if (take_wait > 0) next_ready = 1'b0;
      end else if (!rgb_if.ready) begin
        if (take_wait > 0) take_wait--;
        if (take_wait == 0) next_ready = 1'b1;
      end
      rgb_if.ready <= next_ready;
    end
  end

  // Sampled on the falling edge so that every update of the rising edge has settled.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_colors.size() != 0 || color_if.valid || expected_rgb.size() != 0);
  endtask

  // The sender holds off until the pipeline is empty, then the register is written.
  task automatic set_output_linear(bit value);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    linear_cfg = value;
    n_settings++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [FIELD_W-1:0] pick_fraction();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return FIELD_W'(16'h7FFF + $urandom_range(0, 1));
      3:       return FIELD_W'($urandom_range(2600, 2700));
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    color_req_t req;
    bit random_settings [3];
    random_settings = '{OUT_LINEAR, OUT_SRGB, OUT_LINEAR};
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= OUT_SRGB;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed colors under both output settings.
    set_output_linear(OUT_SRGB);
    foreach (directed_colors[i]) pending_colors.push_back(directed_colors[i]);
    set_output_linear(OUT_LINEAR);
    foreach (directed_colors[i]) pending_colors.push_back(directed_colors[i]);

    // Random colors, in phases that switch the output setting.
    foreach (random_settings[p]) begin
      set_output_linear(random_settings[p]);
      repeat (500) begin
        req.mode  = $urandom_range(0, 1) ? MODE_HSV : MODE_HSL;
        req.hue   = pick_fraction();
        req.sat   = pick_fraction();
        req.level = pick_fraction();
        pending_colors.push_back(req);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d color requests (%0d HSV, %0d with linear output) over %0d settings.",
             n_sent, n_hsv, n_linear, n_settings);
    $display("Checked %0d RGB results, %0d field mismatches.", n_checked, n_mismatch);
    if (n_mismatch == 0 && expected_rgb.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs.
  initial begin : watchdog
    #5_000_000;
    $display("Timeout with %0d results outstanding.", expected_rgb.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/hsvrgb_pkg.sv
hw/rtl/hsvrgb_if.sv
hw/rtl/hsvrgb_color.sv
hw/rtl/hsvrgb_curve_rom.sv
hw/rtl/hsvrgb_decode.sv
hw/rtl/hsl_hsv_to_rgb_converter_top.sv
verif/hsl_hsv_to_rgb_converter_top_tb.sv
